// ===== design/ip_mac_cache_with_aging_defines.svh =====
// assertion macros for the address cache
// used at the end of the top level; expects clk and arst_n in scope
`ifndef IP_MAC_CACHE_WITH_AGING_DEFINES_SVH
`define IP_MAC_CACHE_WITH_AGING_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define AMC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define AMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/amc_pkg.sv =====
// shared types and constants for the address cache
// no dependencies; imported by amc_entry_cmp, the top level and the testbench
package amc_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int IP_W        = 32;
	localparam int MAC_W       = 48;
	localparam int STAMP_W     = 32;
	localparam int TIMEOUT_W   = 12;
	localparam int KIND_W      = 2;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 12'd15;

	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

	localparam logic [APB_AW-3:0] REG_TIMEOUT = '0;

	typedef struct packed {
		logic               valid;
		logic [STAMP_W-1:0] stamp;
		logic [MAC_W-1:0]   mac;
		logic [IP_W-1:0]    ip;
	} entry_t;

	typedef struct packed {
		logic ip_match;
		logic expired;
	} cmp_t;

endpackage

// ===== design/amc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module amc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/amc_entry_cmp.sv =====
// shared compare unit: address match and age expiry for one table entry
// depends on amc_pkg
module amc_entry_cmp (
	input  amc_pkg::entry_t                    entry,
	input  logic [amc_pkg::IP_W-1:0]           key_ip,
	input  logic [amc_pkg::STAMP_W-1:0]        seconds,
	input  logic [amc_pkg::TIMEOUT_W-1:0]      timeout,
	output amc_pkg::cmp_t                      res
);
	import amc_pkg::*;

	logic [STAMP_W-1:0] age;

	always_comb begin
		age          = seconds - entry.stamp;
		res.ip_match = entry.valid && (entry.ip == key_ip);
		res.expired  = entry.valid && (age > STAMP_W'(timeout));
	end

endmodule

// ===== design/ip_mac_cache_with_aging.sv =====
// top level of the ip to mac address cache with ageing
// depends on amc_pkg, amc_ram, amc_entry_cmp and the assertion macro header
//
// An item is a command beat taken when start is high and busy is low: kind picks a lookup,
// an insert or a one-second tick; ip_address and mac_address ride along with it.
// Every command gives exactly one result beat, shown on hit, found_mac and stored for
// a single cycle while done is high. The receiver cannot hold results off.
// The table sits in one ram of ENTRIES words; a small sequencer walks it one entry
// a cycle through a single shared compare unit, so the ram read port sets the rate.
// Lookup and tick scan every entry before done rises, and the next command can be
// taken while done is high. Insert stops at the first free slot, or scans every
// entry when the table is full. The unused kind answers with zeros in the cycle after
// its beat. After reset busy stays high while the ram is swept clear. timeout_seconds
// sits at apb byte address 0; the user must write it only while the block idles, as
// the block itself does not enforce this.
`include "ip_mac_cache_with_aging_defines.svh"
module ip_mac_cache_with_aging #(
	parameter int ENTRIES = amc_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [amc_pkg::KIND_W-1:0]    kind,
	input  logic [amc_pkg::IP_W-1:0]      ip_address,
	input  logic [amc_pkg::MAC_W-1:0]     mac_address,
	output logic                          done,
	output logic                          hit,
	output logic [amc_pkg::MAC_W-1:0]     found_mac,
	output logic                          stored,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [amc_pkg::APB_AW-1:0]    paddr,
	input  logic [amc_pkg::APB_DW-1:0]    pwdata,
	output logic [amc_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import amc_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         idx_q;
	logic                  issue_q;
	logic                  vld_s1;
	logic [AW-1:0]         addr_s1;
	logic [KIND_W-1:0]     kind_q;
	logic [IP_W-1:0]       ip_q;
	logic [MAC_W-1:0]      mac_q;
	logic [STAMP_W-1:0]    sec_q;
	logic [TIMEOUT_W-1:0]  timeout_q;
	logic                  done_q;
	logic                  hit_q;
	logic [MAC_W-1:0]      found_q;
	logic                  stored_q;

	logic                  accept;
	logic                  finish;
	logic                  we;
	logic [AW-1:0]         waddr;
	entry_t                wdata;
	entry_t                rdata;
	cmp_t                  cmp;
	logic [APB_AW-3:0]     reg_idx;

	amc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	amc_entry_cmp u_cmp (
		.entry   (rdata),
		.key_ip  (ip_q),
		.seconds (sec_q),
		.timeout (timeout_q),
		.res     (cmp)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign finish = (state_q == ST_SCAN) && vld_s1 &&
		((addr_s1 == LAST_IDX) || ((kind_q == KIND_INSERT) && !rdata.valid));

	// ram write port: clearing sweep, insert into first free slot, expiry
	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = rdata;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = '0;
			end
			ST_SCAN: begin
				if (vld_s1 && (kind_q == KIND_INSERT) && !rdata.valid) begin
					we          = 1'b1;
					wdata.valid = 1'b1;
					wdata.stamp = sec_q;
					wdata.mac   = mac_q;
					wdata.ip    = ip_q;
				end else if (vld_s1 && (kind_q == KIND_TICK) && cmp.expired) begin
					we          = 1'b1;
					wdata.valid = 1'b0;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			idx_q    <= '0;
			issue_q  <= 1'b0;
			vld_s1   <= 1'b0;
			addr_s1  <= '0;
			kind_q   <= KIND_LOOKUP;
			sec_q    <= '0;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			found_q  <= '0;
			stored_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						kind_q   <= kind;
						hit_q    <= 1'b0;
						found_q  <= '0;
						stored_q <= 1'b0;
						idx_q    <= '0;
						vld_s1   <= 1'b0;
						if (kind == KIND_NONE) begin
							done_q <= 1'b1;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end
						if (kind == KIND_TICK) begin
							sec_q <= sec_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					vld_s1  <= issue_q;
					addr_s1 <= idx_q;
					if (issue_q) begin
						if (idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					// last match wins, so the highest index is reported
					if (vld_s1 && (kind_q == KIND_LOOKUP) && cmp.ip_match) begin
						hit_q   <= 1'b1;
						found_q <= rdata.mac;
					end
					if (vld_s1 && (kind_q == KIND_INSERT) && !rdata.valid) begin
						stored_q <= 1'b1;
					end
					if (finish) begin
						done_q  <= 1'b1;
						issue_q <= 1'b0;
						vld_s1  <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			ip_q  <= ip_address;
			mac_q <= mac_address;
		end
	end

	// configuration port
	assign reg_idx = paddr[APB_AW-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_TIMEOUT)) begin
			timeout_q <= pwdata[TIMEOUT_W-1:0];
		end
	end

	always_comb begin
		if (reg_idx == REG_TIMEOUT) begin
			prdata = APB_DW'(timeout_q);
		end else begin
			prdata = '0;
		end
	end

	assign done      = done_q;
	assign hit       = hit_q;
	assign found_mac = found_q;
	assign stored    = stored_q;

	`AMC_ASSERT_NOW(a_done_idle, done, !busy, "result beat while sequencer busy")
	`AMC_ASSERT_NOW(a_one_kind, done, !(hit && stored), "hit and stored on the same beat")
	`AMC_ASSERT_NOW(a_miss_zero, done && !hit, found_mac == '0, "miss with nonzero mac")
	`AMC_ASSERT_NEXT(a_none_quick, accept && (kind == KIND_NONE), done && !busy, "unused kind not answered")
	`AMC_ASSERT_NEXT(a_scan_busy, accept && (kind != KIND_NONE), busy && !done, "scan did not start")

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for ip_mac_cache_with_aging: a directed table, then random phases
// predicts lookups, inserts and ageing ticks, and checks every result beat against it
// depends on amc_pkg and the ip_mac_cache_with_aging top level
module tb;
	import amc_pkg::*;

	localparam int N_SLOTS = ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [APB_AW-3:0] REG_SPARE = 1'b1;
	localparam logic [APB_AW-1:0] ADDR_TIMEOUT = {REG_TIMEOUT, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_SPARE = {REG_SPARE, 2'b00};

	typedef struct packed {
		logic             hit;
		logic [MAC_W-1:0] mac;
		logic             stored;
	} answer_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		bit                typed;
		answer_t           ans;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [KIND_W-1:0]   kind;
	logic [IP_W-1:0]     ip_address;
	logic [MAC_W-1:0]    mac_address;
	logic                done;
	logic                hit;
	logic [MAC_W-1:0]    found_mac;
	logic                stored;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// mirror of the table and its configuration
	logic                 tbl_valid [N_SLOTS];
	logic [IP_W-1:0]      tbl_ip [N_SLOTS];
	logic [MAC_W-1:0]     tbl_mac [N_SLOTS];
	logic [STAMP_W-1:0]   tbl_stamp [N_SLOTS];
	logic [STAMP_W-1:0]   tbl_seconds;
	logic [TIMEOUT_W-1:0] tbl_timeout;

	answer_t answers_due [$];
	int      fail_count;
	int      cycle_count;
	answer_t want;
	answer_t got;

	row_t dir_rows [19] = '{
		'{KIND_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b0}},
		'{KIND_LOOKUP, 32'hffff_ffff, 48'hffff_ffff_ffff, 1'b1, '{1'b0, 48'h0, 1'b0}},
		'{KIND_INSERT, 32'h0000_0000, 48'h0000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b1}},
		'{KIND_INSERT, 32'hffff_ffff, 48'hffff_ffff_ffff, 1'b1, '{1'b0, 48'h0, 1'b1}},
		'{KIND_LOOKUP, 32'hffff_ffff, 48'h0000_0000_0000, 1'b1,
			'{1'b1, 48'hffff_ffff_ffff, 1'b0}},
		'{KIND_LOOKUP, 32'h0000_0000, 48'hffff_ffff_ffff, 1'b1, '{1'b1, 48'h0, 1'b0}},
		'{KIND_INSERT, 32'hffff_ffff, 48'h0123_4567_89ab, 1'b1, '{1'b0, 48'h0, 1'b1}},
		'{KIND_LOOKUP, 32'hffff_ffff, 48'h0000_0000_0000, 1'b0, '{1'b0, 48'h0, 1'b0}},
		'{KIND_NONE,   32'hffff_ffff, 48'hffff_ffff_ffff, 1'b1, '{1'b0, 48'h0, 1'b0}},
		'{KIND_TICK,   32'h0000_0000, 48'h0000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b0}},
		'{KIND_INSERT, 32'h5555_5555, 48'haaaa_aaaa_aaaa, 1'b1, '{1'b0, 48'h0, 1'b1}},
		'{KIND_INSERT, 32'haaaa_aaaa, 48'h5555_5555_5555, 1'b1, '{1'b0, 48'h0, 1'b1}},
		'{KIND_LOOKUP, 32'h5555_5555, 48'h0000_0000_1234, 1'b0, '{1'b0, 48'h0, 1'b0}},
		'{KIND_LOOKUP, 32'haaaa_aaaa, 48'h0000_0000_0000, 1'b0, '{1'b0, 48'h0, 1'b0}},
		'{KIND_TICK,   32'hffff_ffff, 48'hffff_ffff_ffff, 1'b1, '{1'b0, 48'h0, 1'b0}},
		'{KIND_LOOKUP, 32'h0000_0001, 48'h0000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b0}},
		'{KIND_INSERT, 32'h8000_0000, 48'h8000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b1}},
		'{KIND_LOOKUP, 32'h8000_0000, 48'h0000_0000_0000, 1'b0, '{1'b0, 48'h0, 1'b0}},
		'{KIND_NONE,   32'h0000_0000, 48'h0000_0000_0000, 1'b1, '{1'b0, 48'h0, 1'b0}}
	};

	ip_mac_cache_with_aging uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.ip_address  (ip_address),
		.mac_address (mac_address),
		.done        (done),
		.hit         (hit),
		.found_mac   (found_mac),
		.stored      (stored),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endtask

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[MAC_W-1:0];
	endfunction

	task automatic cache_apply(input logic [KIND_W-1:0] k, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac, output answer_t a);
		int slot;
		logic [STAMP_W-1:0] age;
		a = '0;
		slot = -1;
		case (k)
			KIND_LOOKUP: begin
				for (int i = 0; i < N_SLOTS; i++)
					if (tbl_valid[i] && tbl_ip[i] == ip) begin
						a.hit = 1'b1;
						a.mac = tbl_mac[i];
					end
			end
			KIND_INSERT: begin
				for (int i = 0; i < N_SLOTS; i++)
					if (!tbl_valid[i] && slot < 0) slot = i;
				if (slot >= 0) begin
					tbl_valid[slot] = 1'b1;
					tbl_ip[slot] = ip;
					tbl_mac[slot] = mac;
					tbl_stamp[slot] = tbl_seconds;
					a.stored = 1'b1;
				end
			end
			KIND_TICK: begin
				tbl_seconds = tbl_seconds + 1;
				for (int i = 0; i < N_SLOTS; i++) begin
					age = tbl_seconds - tbl_stamp[i];
					if (tbl_valid[i] && age > STAMP_W'(tbl_timeout)) tbl_valid[i] = 1'b0;
				end
			end
			default: ;
		endcase
	endtask

	// one command beat, with an optional sender gap in front
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac, input int idle_pct, input bit typed,
			input answer_t typed_ans);
		int gap;
		answer_t a;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, N_SLOTS + 6);
			@(negedge clk) start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		kind <= k;
		ip_address <= ip;
		mac_address <= mac;
		do @(posedge clk); while (busy !== 1'b0);
		cache_apply(k, ip, mac, a);
		answers_due.push_back(typed ? typed_ans : a);
	endtask

	task automatic settle();
		@(negedge clk) start <= 1'b0;
		while (answers_due.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_AW-1:0] a, input logic [APB_DW-1:0] d);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (a[APB_AW-1:2] == REG_TIMEOUT) tbl_timeout = d[TIMEOUT_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(input logic [APB_AW-1:0] a, output logic [APB_DW-1:0] d);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		d = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// new timeout, a write to an unused index, then a read back and a burst of traffic
	task automatic run_phase(input int n_items, input int fill_n, input int idle_pct,
			input logic [APB_DW-1:0] tmo_word);
		logic [IP_W-1:0] pool [8];
		logic [APB_DW-1:0] rd;
		logic [IP_W-1:0] ip;
		logic [KIND_W-1:0] k;
		int r;
		settle();
		apb_write(ADDR_TIMEOUT, tmo_word);
		apb_write(ADDR_SPARE, $urandom);
		apb_read(ADDR_TIMEOUT, rd);
		if (rd !== APB_DW'(tbl_timeout))
			note_failure($sformatf("timeout read back: expected %0d, got %0d", tbl_timeout, rd));
		foreach (pool[i]) pool[i] = $urandom;
		for (int n = 0; n < fill_n; n++)
			send_item(KIND_INSERT, pool[$urandom_range(7)], rand_mac(), idle_pct, 1'b0, '0);
		for (int n = 0; n < n_items; n++) begin
			r = $urandom_range(99);
			if (r < 5) k = KIND_NONE;
			else if (r < 40) k = KIND_LOOKUP;
			else if (r < 72) k = KIND_INSERT;
			else k = KIND_TICK;
			ip = ($urandom_range(3) != 0) ? pool[$urandom_range(7)] : $urandom;
			send_item(k, ip, rand_mac(), idle_pct, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ip_mac_cache_with_aging regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			got = '{hit, found_mac, stored};
			if (answers_due.size() == 0) begin
				note_failure($sformatf("result beat with nothing due: hit %0b mac %h stored %0b",
					got.hit, got.mac, got.stored));
			end else begin
				want = answers_due.pop_front();
				if (got.hit !== want.hit || got.mac !== want.mac || got.stored !== want.stored)
					note_failure($sformatf(
						"result mismatch: expected hit %0b mac %h stored %0b, got hit %0b mac %h stored %0b",
						want.hit, want.mac, want.stored, got.hit, got.mac, got.stored));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_LOOKUP;
		ip_address = '0;
		mac_address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		cycle_count = 0;
		foreach (tbl_valid[i]) begin
			tbl_valid[i] = 1'b0;
			tbl_ip[i] = '0;
			tbl_mac[i] = '0;
			tbl_stamp[i] = '0;
		end
		tbl_seconds = '0;
		tbl_timeout = TIMEOUT_RESET;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		settle();
		foreach (dir_rows[i])
			send_item(dir_rows[i].kind, dir_rows[i].ip, dir_rows[i].mac, 0,
				dir_rows[i].typed, dir_rows[i].ans);

		run_phase(60, 0, 18, 32'd0);
		run_phase(60, 70, 18, 32'd3600);
		run_phase(90, 0, 55, 32'd1);
		run_phase(60, 0, 55, 32'd4095);
		run_phase(100, 0, 0, 32'hffff_f005);

		settle();
		repeat (N_SLOTS + 4) @(posedge clk);
		if (fail_count == 0) begin
			$display("ip_mac_cache_with_aging regression: pass");
		end else begin
			$display("ip_mac_cache_with_aging regression: fail");
		end
		$finish;
	end

endmodule

// ===== ip_mac_cache_with_aging.f =====
+incdir+design
design/amc_pkg.sv
design/amc_ram.sv
design/amc_entry_cmp.sv
design/ip_mac_cache_with_aging.sv
dv/tb.sv
